[design/nearest_grid_index_search_defines.svh]
// Assertion macros shared by the nearest grid index search modules.
`ifndef NEAREST_GRID_INDEX_SEARCH_DEFINES_SVH
`define NEAREST_GRID_INDEX_SEARCH_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NGIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nearest grid index search: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define NGIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nearest grid index search: next-cycle check failed");

`endif

[design/ngis_pkg.sv]
// Shared constants, codes and command/status types for the grid index search.
package ngis_pkg;

  localparam int GRID_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int VALUE_W    = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_SEARCH,
    ST_DECIDE,
    ST_PUT
  } state_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_HI,
    RD_MID
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_HI,
    RES_SPLIT
  } res_sel_t;

  typedef struct packed {
    logic     load_query;
    logic     mem_we;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     set_lo_val;
    logic     set_hi_val;
    logic     step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ngis_cmd_t;

  typedef struct packed {
    logic q_le;      // query <= read data
    logic q_ge;      // query >= read data
    logic gap;       // hi - lo > 1 after this cycle's update
    logic out_free;  // output register can take a result this cycle
  } ngis_sts_t;

endpackage

[design/ngis_ctrl.sv]
// Controller state machine for the grid index search.
`include "nearest_grid_index_search_defines.svh"

module ngis_ctrl
  import ngis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      kind,
  output logic      in_stall,
  input  ngis_sts_t sts,
  output ngis_cmd_t cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_QUERY) state_next = ST_CHK_LO;
      end
      ST_CHK_LO: begin
        state_next = sts.q_le ? ST_PUT : ST_CHK_HI;
      end
      ST_CHK_HI: begin
        if (sts.q_ge) state_next = ST_PUT;
        else if (sts.gap) state_next = ST_SEARCH;
        else state_next = ST_DECIDE;
      end
      ST_SEARCH: begin
        if (!sts.gap) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_ZERO;
    cmd.res_sel    = RES_ZERO;
    in_stall       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load_query = accept && kind == KIND_QUERY;
        cmd.mem_we     = accept && kind == KIND_WRITE;
        cmd.rd_en      = accept && kind == KIND_QUERY;
        cmd.rd_sel     = RD_ZERO;
      end
      ST_CHK_LO: begin
        cmd.set_lo_val = 1'b1;
        cmd.res_load   = sts.q_le;
        cmd.res_sel    = RES_ZERO;
        cmd.rd_en      = !sts.q_le;
        cmd.rd_sel     = RD_HI;
      end
      ST_CHK_HI: begin
        cmd.set_hi_val = 1'b1;
        cmd.res_load   = sts.q_ge;
        cmd.res_sel    = RES_HI;
        cmd.rd_en      = !sts.q_ge && sts.gap;
        cmd.rd_sel     = RD_MID;
      end
      ST_SEARCH: begin
        cmd.step   = 1'b1;
        cmd.rd_en  = sts.gap;
        cmd.rd_sel = RD_MID;
      end
      ST_DECIDE: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SPLIT;
      end
      ST_PUT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `NGIS_ASSERT_NEXT(a_query_reads_first, accept && kind == KIND_QUERY, state == ST_CHK_LO)
  `NGIS_ASSERT_NEXT(a_write_stays_idle, accept && kind == KIND_WRITE, state == ST_IDLE)
  `NGIS_ASSERT_NEXT(a_put_holds, state == ST_PUT && !sts.out_free, state == ST_PUT)

endmodule

[design/ngis_datapath.sv]
// Datapath: grid memory, search bounds, final nearness compare and result register.
`include "nearest_grid_index_search_defines.svh"

module ngis_datapath
  import ngis_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  ngis_cmd_t                 cmd,
  output ngis_sts_t                 sts,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [VALUE_W-1:0] entry_value,
  input  logic signed [VALUE_W-1:0] query_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [INDEX_W-1:0]        nearest_index
);

  logic signed [VALUE_W-1:0] mem [GRID_DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic [ADDR_W-1:0]         rd_addr;

  logic [COUNT_W-1:0]        grid_count;
  logic [ADDR_W-1:0]         last_idx;

  logic signed [VALUE_W-1:0] q;
  logic signed [VALUE_W-1:0] lo_val;
  logic signed [VALUE_W-1:0] hi_val;
  logic [ADDR_W-1:0]         lo, lo_next;
  logic [ADDR_W-1:0]         hi, hi_next;
  logic [ADDR_W-1:0]         mid, mid_next;
  logic [ADDR_W:0]           mid_sum;
  logic [ADDR_W-1:0]         span;
  logic [ADDR_W-1:0]         res;
  logic signed [VALUE_W+1:0] pair_sum;
  logic signed [VALUE_W+1:0] q_twice;
  logic                      lower_side;
  logic                      write_ok;

  // Clamp the configured count to 1..GRID_DEPTH and form the last index.
  always_comb begin
    if (grid_count == '0) begin
      last_idx = '0;
    end else if (32'(grid_count) > 32'(GRID_DEPTH)) begin
      last_idx = ADDR_W'(GRID_DEPTH - 1);
    end else begin
      last_idx = ADDR_W'(grid_count - COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_count <= COUNT_W'(1);
    end else if (cfg_wr_en) begin
      grid_count <= cfg_wr_data;
    end
  end

  assign write_ok = 32'(entry_index) < 32'(GRID_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.mem_we && write_ok) begin
      mem[ADDR_W'(entry_index)] <= entry_value;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_HI:   rd_addr = hi;
      RD_MID:  rd_addr = mid_next;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign sts.q_le = (q <= rdata);
  assign sts.q_ge = (q >= rdata);

  // Move one bound to the probed midpoint.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.step) begin
      if (!sts.q_le) lo_next = mid;
      else hi_next = mid;
    end
  end

  assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = mid_sum[ADDR_W:1];
  assign span     = hi_next - lo_next;
  assign sts.gap  = (span > ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q  <= query_value;
      lo <= '0;
      hi <= last_idx;
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.rd_en && cmd.rd_sel == RD_MID) mid <= mid_next;
    if (cmd.set_lo_val || (cmd.step && !sts.q_le)) lo_val <= rdata;
    if (cmd.set_hi_val || (cmd.step && sts.q_le)) hi_val <= rdata;
  end

  // Upper wins when hi_val - q <= q - lo_val, i.e. hi_val + lo_val <= 2q.
  assign pair_sum   = (VALUE_W + 2)'(hi_val) + (VALUE_W + 2)'(lo_val);
  assign q_twice    = (VALUE_W + 2)'(q) <<< 1;
  assign lower_side = (pair_sum > q_twice);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_ZERO:  res <= '0;
        RES_HI:    res <= hi;
        RES_SPLIT: res <= lower_side ? lo : hi;
        default:   res <= '0;
      endcase
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) nearest_index <= INDEX_W'(res);
  end

  `NGIS_ASSERT_SAME(a_mid_inside, cmd.step, lo < mid && mid < hi)
  `NGIS_ASSERT_SAME(a_load_when_free, cmd.out_load, !out_valid || !out_stall)
  `NGIS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid && nearest_index == INDEX_W'($past(res)))

endmodule

[design/nearest_grid_index_search.sv]
// Top level of the nearest grid index search over a sorted fixed-point grid.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   kind, entry_index, entry_value, query_value
//   out       output     out_valid / out_stall nearest_index
//   cfg       input      cfg_wr_en             cfg_wr_data (grid_count)
//
// A write request leaves the controller idle, so the next request can be taken in the cycle after it.
// A query request reads the first entry and ends there at or below it, then reads the last
// entry and ends there at or above it, and otherwise bisects: one grid read per step.
// Reset clears the controller and the output valid and sets grid_count to 1. The grid
// memory is not cleared; users must write it before any query reads it (not enforced).
// A stalled result holds in the output register; the next query waits in its last step.
module nearest_grid_index_search
  import ngis_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [COUNT_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [VALUE_W-1:0] entry_value,
  input  logic signed [VALUE_W-1:0] query_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [INDEX_W-1:0]        nearest_index
);

  ngis_cmd_t cmd;
  ngis_sts_t sts;

  // Sequence the request: accept, probe both ends, bisect, compare, hand off.
  ngis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the grid, the search bounds and the output register.
  ngis_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .query_value   (query_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .nearest_index (nearest_index)
  );

endmodule
